FILE: rtl/cursor_doubly_linked_list_macros.svh
// Assertion macros shared by the list controller.
`ifndef CURSOR_DOUBLY_LINKED_LIST_MACROS_SVH
`define CURSOR_DOUBLY_LINKED_LIST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDLL_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDLL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cdll_pkg.sv
package cdll_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [3:0]
    {
        K_CLEAR    = 4'd0,
        K_ADD_HEAD = 4'd1,
        K_ADD_TAIL = 4'd2,
        K_INSERT   = 4'd3,
        K_FIRST    = 4'd4,
        K_LAST     = 4'd5,
        K_NEXT     = 4'd6,
        K_PREV     = 4'd7,
        K_GET      = 4'd8,
        K_DELETE   = 4'd9
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } status_t;

endpackage

FILE: rtl/cursor_doubly_linked_list.sv
// Channel   Direction  Handshake                    Payload
// command   in         start high while busy low    kind, data_in
// result    out        done strobe, one cycle       status, data_out, count
//
// Clear and refused operations end in S_IDLE; get, first, last and previous from the tail
// sentinel pass S_VALUE; next and previous pass S_STEP, S_VALUE; add and insert pass S_ALLOC,
// S_LINKA, S_LINKB; delete passes S_UNLINK, S_LINKA, S_LINKB. Each link fix-up is one write
// to the single-port node memory. The result beat appears in the cycle after the operation
// finishes; a new command may be taken in that same cycle. Reset leaves an empty list with
// every slot free. The receiver cannot stall, so each result beat is shown exactly once.
`include "cursor_doubly_linked_list_macros.svh"

module cursor_doubly_linked_list
    import cdll_pkg::*;
#(
    parameter int NODES = 256
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [3:0]                       kind,
    input  logic signed [DATA_W-1:0]         data_in,
    output logic                             done,
    output logic [1:0]                       status,
    output logic signed [DATA_W-1:0]         data_out,
    output logic [$clog2(NODES + 1)-1:0]     count
);

    localparam int AW = $clog2(NODES);
    localparam int IW = $clog2(NODES + 2);
    localparam int CW = $clog2(NODES + 1);
    localparam logic [IW-1:0] HEAD_IDX = IW'(NODES);
    localparam logic [IW-1:0] TAIL_IDX = IW'(NODES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(NODES);

    typedef struct packed
    {
        logic [DATA_W-1:0] value;
        logic [IW-1:0]     next;
        logic [IW-1:0]     prev;
    } node_t;

    typedef struct packed
    {
        logic value;
        logic next;
        logic prev;
    } node_we_t;

    typedef enum logic [6:0]
    {
        S_IDLE   = 7'b0000001,
        S_VALUE  = 7'b0000010,
        S_STEP   = 7'b0000100,
        S_ALLOC  = 7'b0001000,
        S_UNLINK = 7'b0010000,
        S_LINKA  = 7'b0100000,
        S_LINKB  = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    kind_t                   op_reg, op_next;
    logic [DATA_W-1:0]       din_reg, din_next;
    logic [IW-1:0]           cursor_reg, cursor_next;
    logic [IW-1:0]           first_reg, first_next;
    logic [IW-1:0]           last_reg, last_next;
    logic [CW-1:0]           length_reg, length_next;
    logic [CW-1:0]           fresh_reg, fresh_next;
    logic [CW-1:0]           ftop_reg, ftop_next;
    logic                    use_stack_reg, use_stack_next;
    logic [AW-1:0]           slot_reg, slot_next;
    logic [IW-1:0]           pa_idx_reg, pa_idx_next;
    logic [IW-1:0]           pa_val_reg, pa_val_next;
    logic [IW-1:0]           pb_idx_reg, pb_idx_next;
    logic [IW-1:0]           pb_val_reg, pb_val_next;
    logic [DATA_W-1:0]       val_reg, val_next;
    logic                    done_reg, done_next;
    status_t                 status_reg, status_next;
    logic [DATA_W-1:0]       dout_reg, dout_next;

    node_t                   node_mem [NODES];
    node_t                   node_rd_reg;
    logic                    node_re;
    logic [AW-1:0]           node_raddr;
    node_we_t                node_we;
    logic [AW-1:0]           node_waddr;
    node_t                   node_wdata;

    logic [AW-1:0]           fs_mem [NODES];
    logic [AW-1:0]           fs_rd_reg;
    logic                    fs_re;
    logic [AW-1:0]           fs_raddr;
    logic                    fs_we;
    logic [AW-1:0]           fs_waddr;
    logic [AW-1:0]           fs_wdata;

    kind_t                   kind_in;
    logic [IW-1:0]           end_idx;
    logic [IW-1:0]           step_idx;
    logic [AW-1:0]           alloc_slot;
    logic [IW-1:0]           slot_link;
    logic [IW-1:0]           add_pv;
    logic [IW-1:0]           add_nx;

    assign kind_in    = kind_t'(kind);
    assign end_idx    = (kind_in == K_FIRST) ? first_reg : last_reg;
    assign step_idx   = (op_reg == K_NEXT) ? node_rd_reg.next : node_rd_reg.prev;
    assign alloc_slot = use_stack_reg ? fs_rd_reg : slot_reg;
    assign slot_link  = IW'(alloc_slot);

    always_comb
    begin
        priority if (op_reg == K_ADD_HEAD)
        begin
            add_pv = HEAD_IDX;
            add_nx = first_reg;
        end
        else if (op_reg == K_ADD_TAIL)
        begin
            add_pv = last_reg;
            add_nx = TAIL_IDX;
        end
        else
        begin
            add_pv = (cursor_reg == TAIL_IDX) ? last_reg : node_rd_reg.prev;
            add_nx = cursor_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        din_next       = din_reg;
        cursor_next    = cursor_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        length_next    = length_reg;
        fresh_next     = fresh_reg;
        ftop_next      = ftop_reg;
        use_stack_next = use_stack_reg;
        slot_next      = slot_reg;
        pa_idx_next    = pa_idx_reg;
        pa_val_next    = pa_val_reg;
        pb_idx_next    = pb_idx_reg;
        pb_val_next    = pb_val_reg;
        val_next       = val_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        dout_next      = dout_reg;
        node_re        = 1'b0;
        node_raddr     = cursor_reg[AW-1:0];
        node_we        = '0;
        node_waddr     = alloc_slot;
        node_wdata     = '0;
        fs_re          = 1'b0;
        fs_raddr       = AW'(ftop_reg - 1'b1);
        fs_we          = 1'b0;
        fs_waddr       = ftop_reg[AW-1:0];
        fs_wdata       = cursor_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = kind_in;
                    din_next = data_in;
                    unique case (kind_in)
                        K_CLEAR:
                        begin
                            first_next  = TAIL_IDX;
                            last_next   = HEAD_IDX;
                            cursor_next = TAIL_IDX;
                            length_next = '0;
                            fresh_next  = '0;
                            ftop_next   = '0;
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            dout_next   = '0;
                        end
                        K_ADD_HEAD, K_ADD_TAIL, K_INSERT:
                        begin
                            if (ftop_reg == '0 && fresh_reg == FULL_CNT)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                                dout_next   = '0;
                            end
                            else
                            begin
                                if (ftop_reg != '0)
                                begin
                                    fs_re          = 1'b1;
                                    ftop_next      = ftop_reg - 1'b1;
                                    use_stack_next = 1'b1;
                                end
                                else
                                begin
                                    slot_next      = fresh_reg[AW-1:0];
                                    fresh_next     = fresh_reg + 1'b1;
                                    use_stack_next = 1'b0;
                                end
                                if (kind_in == K_INSERT && cursor_reg != TAIL_IDX)
                                begin
                                    node_re = 1'b1;
                                end
                                state_next = S_ALLOC;
                            end
                        end
                        K_FIRST, K_LAST:
                        begin
                            if (length_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NONE;
                                dout_next   = '0;
                            end
                            else
                            begin
                                cursor_next = end_idx;
                                node_re     = 1'b1;
                                node_raddr  = end_idx[AW-1:0];
                                state_next  = S_VALUE;
                            end
                        end
                        K_NEXT:
                        begin
                            if (cursor_reg == last_reg || cursor_reg == TAIL_IDX)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NONE;
                                dout_next   = '0;
                            end
                            else
                            begin
                                node_re    = 1'b1;
                                state_next = S_STEP;
                            end
                        end
                        K_PREV:
                        begin
                            if (cursor_reg == first_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NONE;
                                dout_next   = '0;
                            end
                            else if (cursor_reg == TAIL_IDX)
                            begin
                                cursor_next = last_reg;
                                node_re     = 1'b1;
                                node_raddr  = last_reg[AW-1:0];
                                state_next  = S_VALUE;
                            end
                            else
                            begin
                                node_re    = 1'b1;
                                state_next = S_STEP;
                            end
                        end
                        K_GET:
                        begin
                            if (cursor_reg == TAIL_IDX)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NONE;
                                dout_next   = '0;
                            end
                            else
                            begin
                                node_re    = 1'b1;
                                state_next = S_VALUE;
                            end
                        end
                        K_DELETE:
                        begin
                            if (length_reg == '0 || cursor_reg == TAIL_IDX)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NONE;
                                dout_next   = '0;
                            end
                            else
                            begin
                                node_re    = 1'b1;
                                state_next = S_UNLINK;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NONE;
                            dout_next   = '0;
                        end
                    endcase
                end
            end
            S_VALUE:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                dout_next   = node_rd_reg.value;
                state_next  = S_IDLE;
            end
            S_STEP:
            begin
                cursor_next = step_idx;
                node_re     = 1'b1;
                node_raddr  = step_idx[AW-1:0];
                state_next  = S_VALUE;
            end
            S_ALLOC:
            begin
                node_we    = '1;
                node_waddr = alloc_slot;
                node_wdata = '{value: din_reg, next: add_nx, prev: add_pv};
                pa_idx_next = add_pv;
                pa_val_next = slot_link;
                pb_idx_next = add_nx;
                pb_val_next = slot_link;
                if (op_reg == K_INSERT || length_reg == '0)
                begin
                    cursor_next = slot_link;
                end
                length_next = length_reg + 1'b1;
                val_next    = '0;
                state_next  = S_LINKA;
            end
            S_UNLINK:
            begin
                pa_idx_next = node_rd_reg.prev;
                pa_val_next = node_rd_reg.next;
                pb_idx_next = node_rd_reg.next;
                pb_val_next = node_rd_reg.prev;
                val_next    = node_rd_reg.value;
                if (ftop_reg < FULL_CNT)
                begin
                    fs_we     = 1'b1;
                    ftop_next = ftop_reg + 1'b1;
                end
                cursor_next = node_rd_reg.next;
                length_next = length_reg - 1'b1;
                state_next  = S_LINKA;
            end
            S_LINKA:
            begin
                if (pa_idx_reg == HEAD_IDX)
                begin
                    first_next = pa_val_reg;
                end
                else
                begin
                    node_we.next    = 1'b1;
                    node_waddr      = pa_idx_reg[AW-1:0];
                    node_wdata.next = pa_val_reg;
                end
                state_next = S_LINKB;
            end
            S_LINKB:
            begin
                if (pb_idx_reg == TAIL_IDX)
                begin
                    last_next = pb_val_reg;
                end
                else
                begin
                    node_we.prev    = 1'b1;
                    node_waddr      = pb_idx_reg[AW-1:0];
                    node_wdata.prev = pb_val_reg;
                end
                done_next   = 1'b1;
                status_next = ST_OK;
                dout_next   = val_reg;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (node_re)
        begin
            node_rd_reg <= node_mem[node_raddr];
        end
        if (node_we.value)
        begin
            node_mem[node_waddr].value <= node_wdata.value;
        end
        if (node_we.next)
        begin
            node_mem[node_waddr].next <= node_wdata.next;
        end
        if (node_we.prev)
        begin
            node_mem[node_waddr].prev <= node_wdata.prev;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fs_re)
        begin
            fs_rd_reg <= fs_mem[fs_raddr];
        end
        if (fs_we)
        begin
            fs_mem[fs_waddr] <= fs_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= TAIL_IDX;
            first_reg     <= TAIL_IDX;
            last_reg      <= HEAD_IDX;
            length_reg    <= '0;
            fresh_reg     <= '0;
            ftop_reg      <= '0;
            use_stack_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            length_reg    <= length_next;
            fresh_reg     <= fresh_next;
            ftop_reg      <= ftop_next;
            use_stack_reg <= use_stack_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        din_reg    <= din_next;
        slot_reg   <= slot_next;
        pa_idx_reg <= pa_idx_next;
        pa_val_reg <= pa_val_next;
        pb_idx_reg <= pb_idx_next;
        pb_val_reg <= pb_val_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        dout_reg   <= dout_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign data_out = dout_reg;
    assign count    = length_reg;

    `CDLL_ASSERT_IMPLY(a_done_not_busy, done, !busy, "Result beat shown while an operation is in flight.")
    `CDLL_ASSERT_NEXT(a_start_progress, start && !busy, busy || done, "Accepted command neither ran nor finished.")
    `CDLL_ASSERT_IMPLY(a_pool_balance, state_reg == S_IDLE, ({1'b0, ftop_reg} + {1'b0, length_reg}) == {1'b0, fresh_reg}, "Free and used slots do not add up to the slots handed out.")
    `CDLL_ASSERT_IMPLY(a_full_exhausted, done && status == ST_FULL, ftop_reg == '0 && fresh_reg == FULL_CNT, "Pool full reported while a slot is free.")

endmodule

FILE: sim/cdll_checker.sv
module cdll_checker
    import cdll_pkg::*;
#(
    parameter int NODES = 256
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [3:0]                   kind,
    input  logic signed [DATA_W-1:0]     data_in,
    input  logic                         done,
    input  logic [1:0]                   status,
    input  logic signed [DATA_W-1:0]     data_out,
    input  logic [$clog2(NODES + 1)-1:0] count,
    output int                           errors,
    output int                           outstanding,
    output int                           checked
);

    localparam int LW = $clog2(NODES + 2);
    localparam int CW = $clog2(NODES + 1);
    localparam logic [LW-1:0] HEAD = LW'(NODES);
    localparam logic [LW-1:0] TAIL = LW'(NODES + 1);

    typedef struct packed
    {
        status_t           st;
        logic [DATA_W-1:0] dout;
        logic [CW-1:0]     cnt;
    } list_result_t;

    logic [DATA_W-1:0] val_mem  [NODES];
    logic [LW-1:0]     next_mem [NODES];
    logic [LW-1:0]     prev_mem [NODES];
    logic [LW-2:0]     free_mem [NODES];
    logic [LW-1:0]     first_ln;
    logic [LW-1:0]     last_ln;
    logic [LW-1:0]     cur;
    logic [CW-1:0]     len;
    logic [CW-1:0]     fresh;
    logic [CW-1:0]     ftop;

    list_result_t pending_results [$];
    int fail_count = 0;
    int pending_count = 0;
    int result_count = 0;

    assign errors = fail_count;
    assign outstanding = pending_count;
    assign checked = result_count;

    function automatic void wipe_list();
        first_ln = TAIL;
        last_ln = HEAD;
        cur = TAIL;
        len = '0;
        fresh = '0;
        ftop = '0;
    endfunction

    function automatic logic [LW-1:0] link_after(input logic [LW-1:0] idx);
        if (idx == HEAD)
            return first_ln;
        if (idx < NODES)
            return next_mem[idx];
        return TAIL;
    endfunction

    function automatic logic [LW-1:0] link_before(input logic [LW-1:0] idx);
        if (idx == TAIL)
            return last_ln;
        if (idx < NODES)
            return prev_mem[idx];
        return HEAD;
    endfunction

    function automatic void put_after(input logic [LW-1:0] idx, input logic [LW-1:0] v);
        if (idx == HEAD)
            first_ln = v;
        else if (idx < NODES)
            next_mem[idx] = v;
    endfunction

    function automatic void put_before(input logic [LW-1:0] idx, input logic [LW-1:0] v);
        if (idx == TAIL)
            last_ln = v;
        else if (idx < NODES)
            prev_mem[idx] = v;
    endfunction

    function automatic logic [DATA_W-1:0] value_at(input logic [LW-1:0] idx);
        return (idx < NODES) ? val_mem[idx] : '0;
    endfunction

    function automatic list_result_t apply_command(input logic [3:0] k,
                                                   input logic [DATA_W-1:0] d);
        list_result_t r;
        logic [LW-1:0] slot;
        logic [LW-1:0] pv;
        logic [LW-1:0] nx;
        logic got;
        r.st = ST_NONE;
        r.dout = '0;
        slot = '0;
        got = 1'b1;
        case (k)
            K_CLEAR:
            begin
                wipe_list();
                r.st = ST_OK;
            end
            K_ADD_HEAD, K_ADD_TAIL, K_INSERT:
            begin
                if (ftop > 0)
                begin
                    ftop = ftop - 1'b1;
                    slot = LW'(free_mem[ftop]);
                end
                else if (fresh < NODES)
                begin
                    slot = LW'(fresh);
                    fresh = fresh + 1'b1;
                end
                else
                begin
                    got = 1'b0;
                end
                if (!got)
                begin
                    r.st = ST_FULL;
                end
                else
                begin
                    val_mem[slot] = d;
                    if (k == K_ADD_HEAD)
                    begin
                        pv = HEAD;
                        nx = first_ln;
                    end
                    else if (k == K_ADD_TAIL)
                    begin
                        pv = last_ln;
                        nx = TAIL;
                    end
                    else
                    begin
                        pv = link_before(cur);
                        nx = cur;
                    end
                    next_mem[slot] = nx;
                    prev_mem[slot] = pv;
                    put_after(pv, slot);
                    put_before(nx, slot);
                    if (k == K_INSERT || len == 0)
                        cur = slot;
                    len = len + 1'b1;
                    r.st = ST_OK;
                end
            end
            K_FIRST, K_LAST:
            begin
                if (len != 0)
                begin
                    cur = (k == K_FIRST) ? first_ln : last_ln;
                    r.dout = value_at(cur);
                    r.st = ST_OK;
                end
            end
            K_NEXT:
            begin
                if (cur != last_ln && cur != TAIL)
                begin
                    cur = link_after(cur);
                    r.dout = value_at(cur);
                    r.st = ST_OK;
                end
            end
            K_PREV:
            begin
                if (cur != first_ln)
                begin
                    cur = link_before(cur);
                    r.dout = value_at(cur);
                    r.st = ST_OK;
                end
            end
            K_GET:
            begin
                if (cur != TAIL)
                begin
                    r.dout = value_at(cur);
                    r.st = ST_OK;
                end
            end
            K_DELETE:
            begin
                if (len != 0 && cur != TAIL)
                begin
                    nx = link_after(cur);
                    pv = link_before(cur);
                    put_after(pv, nx);
                    put_before(nx, pv);
                    r.dout = value_at(cur);
                    if (cur < NODES && ftop < NODES)
                    begin
                        free_mem[ftop] = cur[LW-2:0];
                        ftop = ftop + 1'b1;
                    end
                    cur = nx;
                    len = len - 1'b1;
                    r.st = ST_OK;
                end
            end
            default:
            begin
            end
        endcase
        r.cnt = len;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        list_result_t want;
        if (!rst_n)
        begin
            wipe_list();
            pending_results.delete();
            pending_count = 0;
        end
        else
        begin
            if (done)
            begin
                result_count++;
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result beat with nothing expected: status %0d data %0h count %0d",
                             $time, status, data_out, count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.st)
                    begin
                        fail_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, status);
                    end
                    if (data_out !== want.dout)
                    begin
                        fail_count++;
                        $display("%0t: data_out expected %h actual %h",
                                 $time, want.dout, data_out);
                    end
                    if (count !== want.cnt)
                    begin
                        fail_count++;
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.cnt, count);
                    end
                end
            end
            if (start && !busy)
                pending_results.push_back(apply_command(kind, data_in));
            pending_count = pending_results.size();
        end
    end

endmodule

FILE: sim/tb_top.sv
module tb_top
    import cdll_pkg::*;
();

    localparam int NODES = 256;
    localparam int CW = $clog2(NODES + 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int SEGMENTS = 5;
    localparam int SEGMENT_LEN = 50;
    localparam int FILL_LEN = 280;
    localparam logic [3:0] K_TOPCODE = '1;

    localparam int MODE_GROW = 0;
    localparam int MODE_WALK = 1;
    localparam int MODE_SHRINK = 2;

    // Percentage weights per command kind, indexed by the mode of the segment.
    localparam int MIX [3][10] = '{
        '{0, 25, 25, 20, 5, 5, 6, 6, 4, 4},
        '{0, 4, 4, 4, 10, 10, 25, 20, 15, 8},
        '{0, 3, 3, 3, 10, 8, 12, 12, 9, 40}
    };
    localparam int IDLE_PCT [3] = '{37, 76, 0};

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [3:0]               kind = '0;
    logic signed [DATA_W-1:0] data_in = '0;
    logic                     busy;
    logic                     done;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data_out;
    logic [CW-1:0]            count;

    int errors;
    int outstanding;
    int checked;
    int sent = 0;
    int cycles = 0;
    int idle_pct = 0;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     outstanding);
            $display("CHECK FAILED");
            $finish;
        end
    end

    cursor_doubly_linked_list #(.NODES(NODES)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .kind     (kind),
        .data_in  (data_in),
        .done     (done),
        .status   (status),
        .data_out (data_out),
        .count    (count)
    );

    cdll_checker #(.NODES(NODES)) scoreboard
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .data_in     (data_in),
        .done        (done),
        .status      (status),
        .data_out    (data_out),
        .count       (count),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked)
    );

    // Entered and left just after a falling edge; the command beat is held until taken.
    task automatic issue(input logic [3:0] k, input logic [DATA_W-1:0] d);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        kind <= k;
        data_in <= d;
        do
            @(posedge clk);
        while (busy);
        sent++;
        @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return {1'b1, {(DATA_W - 1){1'b0}}};
            1: return {1'b0, {(DATA_W - 1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_kind(input int mode);
        int r;
        int acc;
        if ($urandom_range(0, 399) == 0)
            return K_CLEAR;
        if ($urandom_range(0, 99) < 2)
            return 4'($urandom_range(int'(K_DELETE) + 1, int'(K_TOPCODE)));
        r = $urandom_range(0, 99);
        acc = 0;
        for (int i = 0; i < 10; i++)
        begin
            acc += MIX[mode][i];
            if (r < acc)
                return 4'(i);
        end
        return K_GET;
    endfunction

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        idle_pct = IDLE_PCT[0];
        issue(K_PREV, '0);
        issue(K_NEXT, '0);
        issue(K_GET, '0);
        issue(K_DELETE, '0);
        issue(K_FIRST, '0);
        issue(K_LAST, '0);
        issue(K_INSERT, 32'h8000_0000);
        issue(K_ADD_HEAD, 32'h7FFF_FFFF);
        issue(K_ADD_TAIL, '0);
        issue(K_ADD_TAIL, '1);
        issue(K_FIRST, '1);
        issue(K_NEXT, '0);
        issue(K_NEXT, '0);
        issue(K_NEXT, '0);
        issue(K_NEXT, '0);
        issue(K_LAST, '0);
        issue(K_PREV, '0);
        issue(K_INSERT, 32'h1234_5678);
        issue(K_GET, '0);
        issue(K_DELETE, '0);
        issue(K_LAST, '0);
        issue(K_DELETE, '0);
        issue(K_GET, '0);
        issue(K_DELETE, '0);
        issue(K_PREV, '0);
        issue(K_TOPCODE, '1);
        issue(K_CLEAR, '0);

        for (int p = 0; p < 3; p++)
        begin
            idle_pct = IDLE_PCT[p];
            if (p == 2)
            begin
                for (int i = 0; i < FILL_LEN; i++)
                    issue(4'($urandom_range(int'(K_ADD_HEAD), int'(K_INSERT))), pick_value());
            end
            for (int s = 0; s < SEGMENTS; s++)
            begin
                int mode;
                mode = (p == 2 && s == 0) ? MODE_SHRINK : $urandom_range(MODE_GROW, MODE_SHRINK);
                for (int i = 0; i < SEGMENT_LEN; i++)
                    issue(pick_kind(mode), pick_value());
            end
            if (p == 0)
            begin
                // Hold the command channel quiet until every result beat is back.
                start <= 1'b0;
                wait (outstanding == 0);
                @(negedge clk);
            end
        end

        start <= 1'b0;
        wait (outstanding == 0);
        repeat (8) @(negedge clk);

        $display("Run issued %0d commands: directed corners, grow, walk and shrink mixes,",
                 sent);
        $display("a pool-fill burst and three idling profiles; %0d result beats compared.",
                 checked);
        if (errors == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
